@@ sv/gh_pkg.sv @@
// Shared types, constants and the GF(2^128) multiply for the GHASH accumulator.
`default_nettype none

package gh_pkg;

    // Operation codes carried in the opcode field
    localparam logic [1:0] GH_OP_AAD    = 2'd0;
    localparam logic [1:0] GH_OP_TEXT   = 2'd1;
    localparam logic [1:0] GH_OP_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic GH_CFG_KEY_HI = 1'b0;
    localparam logic GH_CFG_KEY_LO = 1'b1;

    localparam logic [4:0] GH_BLOCK_BYTES = 5'd16;
    localparam int         GH_COUNT_W     = 61;
    localparam int         GH_QUEUE_DEPTH = 4;

    // One queued job for the back end: a block to fold in, and whether it is the
    // length block that closes the message.
    typedef struct packed {
        logic         finish;
        logic [127:0] block;
    } gh_entry_t;

    // Multiply two field elements in GCM bit order. Bit 127 of the packed word
    // is the x^0 coefficient; reduction is by x^128 + x^7 + x^2 + x + 1.
    function automatic logic [127:0] gh_gf_mul(input logic [127:0] a,
                                               input logic [127:0] b);
        logic [127:0] ar;
        logic [127:0] br;
        logic [254:0] c;
        logic [127:0] p;
        logic [126:0] d;
        logic [133:0] t;
        logic [5:0]   e;
        logic [127:0] r;
        logic [127:0] res;
        int           j;
        for (int i = 0; i < 128; i++)
        begin
            ar[i] = a[127 - i];
            br[i] = b[127 - i];
        end
        // Carry-less product, one XOR tree per product bit
        for (int k = 0; k < 255; k++)
        begin
            for (int i = 0; i < 128; i++)
            begin
                j = k - i;
                if (j >= 0 && j < 128)
                    p[i] = ar[i] & br[j];
                else
                    p[i] = 1'b0;
            end
            c[k] = ^p;
        end
        // Fold the high half twice; the second pass covers the spill of the first
        d = c[254:128];
        t = {6'b0, c[127:0]} ^ {7'b0, d} ^ {6'b0, d, 1'b0} ^ {5'b0, d, 2'b0}
            ^ {d, 7'b0};
        e = t[133:128];
        r = t[127:0] ^ {122'b0, e} ^ {121'b0, e, 1'b0} ^ {120'b0, e, 2'b0}
            ^ {115'b0, e, 7'b0};
        for (int i = 0; i < 128; i++)
            res[i] = r[127 - i];
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/gh_front.sv @@
// Front end: accepts input beats, masks partial blocks, keeps byte totals.
`default_nettype none

module gh_front
    import gh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             queue_full,
    input  wire logic [1:0]       opcode,
    input  wire logic [63:0]      data_hi,
    input  wire logic [63:0]      data_lo,
    input  wire logic [4:0]       byte_count,
    output logic                  in_stall,
    output logic                  push,
    output gh_entry_t             push_entry
);

    logic [GH_COUNT_W-1:0] aad_total_reg;
    logic [GH_COUNT_W-1:0] aad_total_next;
    logic [GH_COUNT_W-1:0] text_total_reg;
    logic [GH_COUNT_W-1:0] text_total_next;
    logic                  accept;
    logic [4:0]            n_sat;
    logic [127:0]          keep_mask;
    logic                  is_absorb;

    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    // Clamp oversize counts to a full block
    assign n_sat     = (byte_count > GH_BLOCK_BYTES) ? GH_BLOCK_BYTES : byte_count;
    assign keep_mask = ~({128{1'b1}} >> {n_sat, 3'b000});
    assign is_absorb = ((opcode == GH_OP_AAD) || (opcode == GH_OP_TEXT))
                       && (n_sat != 5'd0);

    always_comb
    begin
        push            = 1'b0;
        push_entry      = '0;
        aad_total_next  = aad_total_reg;
        text_total_next = text_total_reg;
        if (accept)
        begin
            if (is_absorb)
            begin
                push             = 1'b1;
                push_entry.block = {data_hi, data_lo} & keep_mask;
                if (opcode == GH_OP_AAD)
                    aad_total_next = aad_total_reg + {{(GH_COUNT_W-5){1'b0}}, n_sat};
                else
                    text_total_next = text_total_reg + {{(GH_COUNT_W-5){1'b0}}, n_sat};
            end
            else if (opcode == GH_OP_FINISH)
            begin
                // Length block: bit counts, byte totals times eight
                push              = 1'b1;
                push_entry.finish = 1'b1;
                push_entry.block  = {aad_total_reg, 3'b000, text_total_reg, 3'b000};
                aad_total_next    = '0;
                text_total_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aad_total_reg  <= '0;
            text_total_reg <= '0;
        end
        else
        begin
            aad_total_reg  <= aad_total_next;
            text_total_reg <= text_total_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/gh_queue.sv @@
// Short FIFO of block jobs between the front and back ends.
`default_nettype none

module gh_queue
    import gh_pkg::*;
#(
    parameter int DEPTH = GH_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire gh_entry_t  push_entry,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output gh_entry_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gh_entry_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

@@ sv/gh_back.sv @@
// Back end: folds blocks into the accumulator and drives the digest register.
`default_nettype none

module gh_back
    import gh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    input  wire gh_entry_t    job,
    input  wire logic [127:0] hash_key,
    input  wire logic         out_stall,
    output logic              pop,
    output logic              out_valid,
    output logic [63:0]       digest_hi,
    output logic [63:0]       digest_lo
);

    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic         res_valid_reg;
    logic         res_valid_next;
    logic [127:0] res_data_reg;
    logic [127:0] product;
    logic         load_res;

    assign product = gh_gf_mul(acc_reg ^ job.block, hash_key);

    // A finish job waits only while the digest register is held by the consumer
    assign pop      = job_valid & (~job.finish | ~res_valid_reg | ~out_stall);
    assign load_res = pop & job.finish;

    always_comb
    begin
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg & out_stall;
        if (pop)
            acc_next = job.finish ? '0 : product;
        if (load_res)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
            res_data_reg <= product;
    end

    assign out_valid = res_valid_reg;
    assign digest_hi = res_data_reg[127:64];
    assign digest_lo = res_data_reg[63:0];

endmodule

`default_nettype wire

@@ sv/gcm_ghash_accumulator_top.sv @@
// Top level of the GHASH accumulator: key registers, front end, job queue, back end.
`default_nettype none

//  Channel   Direction  Handshake             Payload
//  in        input      in_valid / in_stall   opcode, data_hi, data_lo, byte_count
//  out       output     out_valid / out_stall digest_hi, digest_lo
//  cfg       input      cfg_write             cfg_index, cfg_data
//
//  One beat per cycle is taken on the input while in_stall is low; each block
//  costs one pass through the combinational GF(2^128) multiply in the back end,
//  which closes the accumulator loop, so the sustained rate is one item per cycle.
//  out_valid rises when a finish job leaves the queue and loads the digest register.
//  Reset clears the key, the accumulator, the byte totals and the queue at once.
//  in_stall rises only when the job queue is full; that happens only while a
//  finished digest waits on out_stall and further work backs up behind it.

module gcm_ghash_accumulator_top
    import gh_pkg::*;
#(
    parameter int QUEUE_DEPTH = GH_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input beats
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] data_hi,
    input  wire logic [63:0] data_lo,
    input  wire logic [4:0]  byte_count,
    // Digest beats
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_hi,
    output logic [63:0]      digest_lo,
    // Configuration writes
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] key_hi_reg;
    logic [63:0] key_lo_reg;
    logic        push;
    gh_entry_t   push_entry;
    logic        pop;
    logic        queue_full;
    logic        queue_not_empty;
    gh_entry_t   head;

    // Hash subkey; the user must write it only while the block is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                GH_CFG_KEY_HI: key_hi_reg <= cfg_data;
                GH_CFG_KEY_LO: key_lo_reg <= cfg_data;
                default:       key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    // Classify and mask beats, count bytes, build the length block on finish
    gh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .opcode     (opcode),
        .data_hi    (data_hi),
        .data_lo    (data_lo),
        .byte_count (byte_count),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the front from a back end held up by the digest consumer
    gh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    // Accumulate and emit
    gh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head),
        .hash_key  ({key_hi_reg, key_lo_reg}),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .digest_hi (digest_hi),
        .digest_lo (digest_lo)
    );

endmodule

`default_nettype wire

@@ sv/gh_checker.sv @@
// Port-level checker for the GHASH accumulator, bound to the top level.
`default_nettype none

module gh_checker
    import gh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] digest_hi,
    input  wire logic [63:0] digest_lo
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       fin_accept;
    logic       out_accept;

    assign fin_accept = in_valid & ~in_stall & (opcode == GH_OP_FINISH);
    assign out_accept = out_valid & ~out_stall;

    // Finish beats taken but whose digest has not yet left
    always_comb
    begin
        pending_next = pending_reg;
        if (fin_accept && !out_accept)
            pending_next = pending_reg + 1'b1;
        else if (out_accept && !fin_accept)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("digest beat dropped while stalled");

    a_digest_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(digest_hi) && $stable(digest_lo))
        else $error("digest changed while stalled");

    a_no_spurious_digest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("digest without a finish beat");

    a_stall_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose with no beat taken");

endmodule

bind gcm_ghash_accumulator_top gh_checker u_gh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest_hi (digest_hi),
    .digest_lo (digest_lo)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the GHASH accumulator: directed table, random messages, scoreboard.
`timescale 1ns / 100ps

module tb_top
    import gh_pkg::*;
();

    // Opcode three has no meaning; the block must drop it without a trace
    localparam logic [1:0]   OP_UNUSED    = 2'd3;
    localparam logic [63:0]  ONES         = 64'hFFFF_FFFF_FFFF_FFFF;
    // H = 1 in GCM bit order, so every multiply returns its operand unchanged
    localparam logic [63:0]  KEY_UNIT_HI  = 64'h8000_0000_0000_0000;
    localparam logic [7:0]   GF_REDUCE    = 8'hE1;
    localparam int           SETTLE_CYCLES = 8;
    localparam int           HOLD_CYCLES  = 80;
    localparam int           QUIET_LIMIT  = 2000;
    localparam int           PHASE_BEATS  = 66;
    localparam int           PHASE_COUNT  = 6;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode     = GH_OP_AAD;
    logic [63:0] data_hi    = '0;
    logic [63:0] data_lo    = '0;
    logic [4:0]  byte_count = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [63:0] digest_hi;
    logic [63:0] digest_lo;
    logic        cfg_write  = 1'b0;
    logic        cfg_index  = GH_CFG_KEY_HI;
    logic [63:0] cfg_data   = '0;

    // Typed-in digest that rides along with the current input beat
    logic        beat_typed   = 1'b0;
    logic [63:0] beat_want_hi = '0;
    logic [63:0] beat_want_lo = '0;

    // Predictor state: hash subkey, running GHASH value, byte totals
    logic [127:0]          key_h      = '0;
    logic [127:0]          hash_acc   = '0;
    logic [GH_COUNT_W-1:0] aad_bytes  = '0;
    logic [GH_COUNT_W-1:0] text_bytes = '0;

    logic [127:0] digest_q [$];
    int           mismatches  = 0;
    int           quiet_cycles = 0;
    int           live_beats  = 0;
    bit           calm        = 1'b0;
    bit           hold_req    = 1'b0;

    typedef struct {
        bit          load_key;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [1:0]  op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  count;
        bit          typed;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
    } beat_vec_t;

    beat_vec_t directed_rows [$];

    always #2 clk = ~clk;

    gcm_ghash_accumulator_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data_hi    (data_hi),
        .data_lo    (data_lo),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_hi  (digest_hi),
        .digest_lo  (digest_lo),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Shift-and-add multiply of x by the subkey; walk x from its x^0 coefficient (MSB) up
    function automatic logic [127:0] gf_times_key(input logic [127:0] x);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = key_h;
        for (int i = 0; i < 128; i++)
        begin
            if (x[127 - i])
                z ^= v;
            carry = v[0];
            v = v >> 1;
            if (carry)
                v[127:120] ^= GF_REDUCE;
        end
        return z;
    endfunction

    // Advance the predictor by one accepted beat; return 1 and the digest on finish
    function automatic bit ghash_beat(input logic [1:0] op, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic [4:0] count,
                                      output logic [127:0] digest);
        logic [127:0] block;
        logic [4:0]   n;
        digest = '0;
        if (op == GH_OP_AAD || op == GH_OP_TEXT)
        begin
            // An empty block is dropped: no multiply, totals hold
            if (count != 0)
            begin
                n = (count > GH_BLOCK_BYTES) ? GH_BLOCK_BYTES : count;
                block = {hi, lo} & ({128{1'b1}} << (8 * (int'(GH_BLOCK_BYTES) - int'(n))));
                hash_acc = gf_times_key(hash_acc ^ block);
                if (op == GH_OP_AAD)
                    aad_bytes = aad_bytes + n;
                else
                    text_bytes = text_bytes + n;
            end
            return 1'b0;
        end
        if (op == GH_OP_FINISH)
        begin
            // Fold in the length block: bit counts, AAD in the upper half
            hash_acc = gf_times_key(hash_acc ^ {aad_bytes, 3'b000, text_bytes, 3'b000});
            digest = hash_acc;
            hash_acc = '0;
            aad_bytes = '0;
            text_bytes = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Scoreboard: check digest beats, predict on input beats, track key writes
    always @(posedge clk)
    begin : track_beats
        logic [127:0] want;
        logic [127:0] fresh;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                    report_mismatch($sformatf("digest %h_%h with none pending",
                                              digest_hi, digest_lo));
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_hi !== want[127:64])
                        report_mismatch($sformatf("digest_hi got %h want %h",
                                                  digest_hi, want[127:64]));
                    if (digest_lo !== want[63:0])
                        report_mismatch($sformatf("digest_lo got %h want %h",
                                                  digest_lo, want[63:0]));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (ghash_beat(opcode, data_hi, data_lo, byte_count, fresh))
                    digest_q.push_back(beat_typed ? {beat_want_hi, beat_want_lo} : fresh);
            end
            if (cfg_write)
            begin
                if (cfg_index == GH_CFG_KEY_HI)
                    key_h[127:64] = cfg_data;
                else
                    key_h[63:0] = cfg_data;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("gcm_ghash_accumulator_top regression: fail");
        $finish;
    end

    // Receiver: stall at random, hold off for a long stretch once on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 13);
        end
    end

    task automatic add_vector(input bit load, input logic [63:0] khi, input logic [63:0] klo,
                              input logic [1:0] op, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [4:0] count,
                              input bit typed, input logic [63:0] whi,
                              input logic [63:0] wlo);
        beat_vec_t v;
        v.load_key = load;
        v.key_hi   = khi;
        v.key_lo   = klo;
        v.op       = op;
        v.hi       = hi;
        v.lo       = lo;
        v.count    = count;
        v.typed    = typed;
        v.want_hi  = whi;
        v.want_lo  = wlo;
        directed_rows.push_back(v);
    endtask

    // Offer one beat, idling first at random; hold the payload until it is taken
    task automatic send_beat(input logic [1:0] op, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [4:0] count,
                             input bit typed, input logic [63:0] whi,
                             input logic [63:0] wlo);
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        data_hi      <= hi;
        data_lo      <= lo;
        byte_count   <= count;
        beat_typed   <= typed;
        beat_want_hi <= whi;
        beat_want_lo <= wlo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Count only beats the block acts on
        if (op == GH_OP_FINISH || ((op == GH_OP_AAD || op == GH_OP_TEXT) && count != 0))
            live_beats++;
    endtask

    // Drop valid, let the scoreboard log the last beat, wait out every pending
    // digest, then let the back end go quiet
    task automatic await_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        cfg_write <= 1'b1;
        cfg_index <= GH_CFG_KEY_HI;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= GH_CFG_KEY_LO;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Data block with random content; noisy messages slip in junk beats
    task automatic send_block(input logic [1:0] op, input logic [4:0] count, input bit noisy);
        if (noisy && $urandom_range(0, 2) == 0)
            send_beat(2'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom},
                      5'($urandom_range(0, 31)), 1'b0, '0, '0);
        send_beat(op, {$urandom, $urandom}, {$urandom, $urandom}, count, 1'b0, '0, '0);
    endtask

    // One GCM message: full AAD blocks, the last possibly partial; same for text; then finish
    task automatic send_message();
        int n_aad;
        int n_text;
        bit noisy;
        logic [4:0] last;
        noisy  = ($urandom_range(0, 99) < 15);
        n_aad  = $urandom_range(0, 3);
        n_text = $urandom_range(0, 5);
        for (int i = 0; i < n_aad; i++)
        begin
            last = noisy ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
            send_block(GH_OP_AAD, (i == n_aad - 1) ? last : GH_BLOCK_BYTES, noisy);
        end
        for (int i = 0; i < n_text; i++)
        begin
            last = noisy ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
            send_block(GH_OP_TEXT, (i == n_text - 1) ? last : GH_BLOCK_BYTES, noisy);
        end
        if (noisy)
            send_block(2'($urandom_range(0, 1)), 5'($urandom_range(1, 31)), noisy);
        // Finish ignores its data fields; drive them at random anyway
        send_beat(GH_OP_FINISH, {$urandom, $urandom}, {$urandom, $urandom},
                  5'($urandom_range(0, 31)), 1'b0, '0, '0);
    endtask

    initial
    begin : stimulus
        int          phase_start;
        logic [63:0] khi;
        logic [63:0] klo;

        // Zero key: every digest collapses to zero
        add_vector(1, '0, '0, GH_OP_AAD, ONES, ONES, GH_BLOCK_BYTES, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_TEXT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   5'd12, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1, '0, '0);
        // Unit key: digest is the XOR of the masked blocks and the length block
        add_vector(1, KEY_UNIT_HI, '0, GH_OP_AAD, ONES, ONES, 5'd0, 0, '0, '0);
        add_vector(0, '0, '0, OP_UNUSED, ONES, ONES, 5'd31, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, ONES, ONES, 5'd31, 1, '0, '0);
        add_vector(0, '0, '0, GH_OP_AAD, ONES, ONES, GH_BLOCK_BYTES, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1,
                   64'hFFFF_FFFF_FFFF_FF7F, ONES);
        // Byte count above sixteen saturates to a full block
        add_vector(0, '0, '0, GH_OP_TEXT, ONES, ONES, 5'd31, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1,
                   ONES, 64'hFFFF_FFFF_FFFF_FF7F);
        // Partial blocks on both sides of the word boundary
        add_vector(0, '0, '0, GH_OP_AAD, ONES, ONES, 5'd1, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_TEXT, ONES, ONES, 5'd8, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_TEXT, ONES, ONES, 5'd9, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_AAD, ONES, ONES, 5'd15, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1,
                   64'h00FF_FFFF_FFFF_FF7F, 64'h00FF_FFFF_FFFF_FF88);
        add_vector(0, '0, '0, GH_OP_AAD, '0, '0, GH_BLOCK_BYTES, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1, 64'h80, '0);
        // All-ones key: leave these to the predictor
        add_vector(1, ONES, ONES, GH_OP_AAD, 64'h0123_4567_89AB_CDEF,
                   64'hFEDC_BA98_7654_3210, GH_BLOCK_BYTES, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_TEXT, ONES, '0, 5'd7, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_TEXT, '0, ONES, 5'd13, 0, '0, '0);
        add_vector(0, '0, '0, GH_OP_FINISH, ONES, ONES, GH_BLOCK_BYTES, 0, '0, '0);
        // Empty message: length block is zero, so is the digest
        add_vector(0, '0, '0, GH_OP_FINISH, '0, '0, '0, 1, '0, '0);

        // Hold reset low, then release it once
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; load a new key only with the block idle
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load_key)
            begin
                await_digests();
                write_key(directed_rows[i].key_hi, directed_rows[i].key_lo);
            end
            send_beat(directed_rows[i].op, directed_rows[i].hi, directed_rows[i].lo,
                      directed_rows[i].count, directed_rows[i].typed,
                      directed_rows[i].want_hi, directed_rows[i].want_lo);
        end

        // Random messages in phases, each under its own key
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            await_digests();
            khi = {$urandom, $urandom};
            klo = {$urandom, $urandom};
            case (phase)
                0:
                begin
                    khi = ONES;
                    klo = ONES;
                end
                1:
                begin
                    khi = KEY_UNIT_HI;
                    klo = '0;
                end
                4: klo = '0;
                default: ;
            endcase
            write_key(khi, klo);
            // One phase runs with no idling on either side
            calm = (phase == 3);
            // Back up the queue behind a held digest so in_stall rises
            if (phase == 2)
                hold_req = 1'b1;
            phase_start = live_beats;
            while (live_beats - phase_start < PHASE_BEATS)
                send_message();
        end
        calm = 1'b0;

        await_digests();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("gcm_ghash_accumulator_top regression: pass");
        else
            $display("gcm_ghash_accumulator_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gh_pkg.sv
sv/gh_front.sv
sv/gh_queue.sv
sv/gh_back.sv
sv/gcm_ghash_accumulator_top.sv
sv/gh_checker.sv
tb/tb_top.sv
